// ===== rtl/gn2d_pkg.sv =====
// Shared types, field widths and the gradient generator for the 2D gradient noise block.
// No dependencies; gradient_noise_2d and the testbench import this package.
package gn2d_pkg;

  localparam int PERM_W  = 8;
  localparam int JIT_W   = 12;
  localparam int COORD_W = 32;
  localparam int NOISE_W = 16;
  localparam int GRAD_W  = 16;

  typedef struct packed {
    logic                       action;
    logic [7:0]                 table_index;
    logic [PERM_W-1:0]          perm_value;
    logic [JIT_W-1:0]           jitter_x_value;
    logic [JIT_W-1:0]           jitter_y_value;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
  } gn2d_in_t;

  typedef struct packed {
    logic signed [NOISE_W-1:0] noise_value;
    logic                      is_noise;
  } gn2d_out_t;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  // Polynomial sine over one quarter turn, z in Q14 (0..16384), result in Q1.14.
  function automatic logic signed [GRAD_W-1:0] quarter_sine(input longint z);
    longint z2;
    longint t;
    longint u;
    z2 = (z * z) >>> 14;
    t  = 10512 - ((z2 * 1160) >>> 14);
    u  = 25736 - ((z2 * t) >>> 14);
    return GRAD_W'((z * u) >>> 14);
  endfunction

  // Sine of a phase with 65536 steps per turn; used only at elaboration.
  function automatic logic signed [GRAD_W-1:0] turn_sine(input int ph);
    int                        q;
    int                        z;
    logic signed [GRAD_W-1:0]  m;
    q = (ph >> 14) & 3;
    z = ph & 16383;
    m = ((q & 1) != 0) ? quarter_sine(longint'(16384 - z)) : quarter_sine(longint'(z));
    return ((q & 2) != 0) ? -m : m;
  endfunction

endpackage

// ===== rtl/gradient_noise_2d.sv =====
// Top level of the 2D jittered gradient noise block.
// Depends on gn2d_pkg and gn2d_ram.
//
// The block keeps a permutation table and two jitter tables in single-port
// RAMs and takes one beat at a time. A load beat writes one entry of all
// three tables and is acknowledged with a zero result. An evaluate beat takes
// a signed Q16.16 point, reads the three permutation entries of the lattice
// columns around it, then visits the 3x3 lattice cells one after another:
// each cell does a hash read, a jitter read with a gradient ROM lookup, and
// five registered arithmetic steps (offsets, squares and dot products,
// falloff, weight, weighted term) before its term is added to the running
// sum. An evaluate runs this cell sequence nine times over the shared
// memories and multipliers. The result sits in an output register, so a new
// beat is taken while a finished result still waits downstream. The tables
// hold nothing meaningful after reset; every entry must be loaded before an
// evaluate reads it. TABLE_SIZE must be a power of two; lattice coordinates
// and hashes wrap modulo TABLE_SIZE.
module gradient_noise_2d #(
  parameter int TABLE_SIZE = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gn2d_pkg::gn2d_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gn2d_pkg::gn2d_out_t out_data
);
  import gn2d_pkg::*;

  localparam int AW      = $clog2(TABLE_SIZE);
  localparam int PH_STEP = 65536 / TABLE_SIZE;
  localparam int D_W     = 19;
  localparam int SUM_W   = 58;
  localparam int RND_SH  = 34;
  localparam int Q_W     = SUM_W - RND_SH;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HASH1 = 4'b0010,
    S_CELL  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic [1:0] ci_r, ci_nxt;
  logic [1:0] cj_r, cj_nxt;

  logic              mode_r;
  logic [15:0]       fx_r, fy_r;
  logic [AW-1:0]     cx_r, cy_r;
  logic [PERM_W-1:0] h1_r [3];

  logic in_acc;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Gradient ROM: cosine and sine of 2*pi*k/TABLE_SIZE, built at elaboration.
  logic [2*GRAD_W-1:0] grad_rom [TABLE_SIZE];
  for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_rom
    localparam int PH = (k * PH_STEP) % 65536;
    assign grad_rom[k] = {turn_sine((PH + 16384) % 65536), turn_sine(PH)};
  end

  // Table memories: permutation, and both jitters side by side.
  logic                 ld_we;
  logic [AW-1:0]        ld_idx;
  logic [AW-1:0]        perm_addr, hash1_addr, hash_addr, jit_addr;
  logic [PERM_W-1:0]    perm_rdata;
  logic [2*JIT_W-1:0]   jit_rdata;

  assign ld_we      = in_acc && (in_data.action == ACT_LOAD);
  assign ld_idx     = AW'(in_data.table_index);
  assign hash1_addr = cx_r + AW'(step_r) + {AW{1'b1}};
  assign hash_addr  = AW'(h1_r[ci_r]) + cy_r + AW'(cj_r) + {AW{1'b1}};
  assign perm_addr  = ld_we ? ld_idx : ((state_r == S_HASH1) ? hash1_addr : hash_addr);
  assign jit_addr   = ld_we ? ld_idx : AW'(perm_rdata);

  gn2d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm (
    .clk   (clk),
    .we    (ld_we),
    .addr  (perm_addr),
    .wdata (in_data.perm_value),
    .rdata (perm_rdata)
  );

  gn2d_ram #(.WIDTH(2*JIT_W), .DEPTH(TABLE_SIZE)) u_jit (
    .clk   (clk),
    .we    (ld_we),
    .addr  (jit_addr),
    .wdata ({in_data.jitter_x_value, in_data.jitter_y_value}),
    .rdata (jit_rdata)
  );

  // Per-cell datapath registers.
  logic [2*GRAD_W-1:0]       grad_q_r;
  logic signed [D_W-1:0]     dx_r, dy_r;
  logic [15:0]               ax_r, ay_r, a2x_r, a2y_r;
  logic                      farx_r, fary_r;
  logic signed [34:0]        pgx_r, pgy_r;
  logic [16:0]               ffx_r, ffy_r;
  logic signed [35:0]        dot_r;
  logic [16:0]               w_r;
  logic signed [53:0]        term_r;
  logic signed [SUM_W-1:0]   sum_r;

  // Offsets from the jittered lattice point.
  logic signed [D_W-1:0] offx, offy, dx_c, dy_c;
  always_comb begin
    case (ci_r)
      2'd0:    offx = D_W'(65536);
      2'd1:    offx = '0;
      default: offx = -D_W'(65536);
    endcase
    case (cj_r)
      2'd0:    offy = D_W'(65536);
      2'd1:    offy = '0;
      default: offy = -D_W'(65536);
    endcase
    dx_c = $signed({3'b0, fx_r}) + offx - $signed({3'b0, jit_rdata[2*JIT_W-1:JIT_W], 4'b0});
    dy_c = $signed({3'b0, fy_r}) + offy - $signed({3'b0, jit_rdata[JIT_W-1:0], 4'b0});
  end

  // Magnitudes and squares of the offsets.
  logic [D_W-1:0] abx, aby;
  logic [31:0]    sqx, sqy;
  always_comb begin
    abx = dx_r[D_W-1] ? D_W'(-dx_r) : D_W'(dx_r);
    aby = dy_r[D_W-1] ? D_W'(-dy_r) : D_W'(dy_r);
    sqx = abx[15:0] * abx[15:0];
    sqy = aby[15:0] * aby[15:0];
  end

  // Falloff 1 - (3 - 2a) a^2, zero outside the unit cell.
  logic [17:0] kx, ky;
  logic [33:0] px, py, wp;
  always_comb begin
    kx = 18'(196608) - {1'b0, ax_r, 1'b0};
    ky = 18'(196608) - {1'b0, ay_r, 1'b0};
    px = kx * a2x_r;
    py = ky * a2y_r;
    wp = ffx_r * ffy_r;
  end

  // Round the Q46 sum to Q12 and saturate.
  logic signed [SUM_W-1:0]   rsum;
  logic signed [Q_W-1:0]     vq;
  logic signed [NOISE_W-1:0] noise_c;
  always_comb begin
    rsum = sum_r + (SUM_W'(1) << (RND_SH - 1));
    vq   = rsum[SUM_W-1:RND_SH];
    if (vq > Q_W'(32767)) begin
      noise_c = 16'sh7fff;
    end else if (vq < -Q_W'(32768)) begin
      noise_c = 16'sh8000;
    end else begin
      noise_c = vq[NOISE_W-1:0];
    end
  end

  // Sequencer.
  logic out_load;
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ci_nxt    = ci_r;
    cj_nxt    = cj_r;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        ci_nxt   = '0;
        cj_nxt   = '0;
        if (in_acc) begin
          state_nxt = (in_data.action == ACT_EVAL) ? S_HASH1 : S_DONE;
        end
      end
      S_HASH1: begin
        if (step_r == 3'd3) begin
          step_nxt  = '0;
          state_nxt = S_CELL;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_CELL: begin
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) begin
          if (ci_r == 2'd2) begin
            ci_nxt = '0;
            if (cj_r == 2'd2) begin
              state_nxt = S_DONE;
            end else begin
              cj_nxt = cj_r + 2'd1;
            end
          end else begin
            ci_nxt = ci_r + 2'd1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      step_r    <= '0;
      ci_r      <= '0;
      cj_r      <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      ci_r    <= ci_nxt;
      cj_r    <= cj_nxt;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_data.action;
      fx_r   <= in_data.coord_x[15:0];
      fy_r   <= in_data.coord_y[15:0];
      cx_r   <= in_data.coord_x[16 +: AW];
      cy_r   <= in_data.coord_y[16 +: AW];
      sum_r  <= '0;
    end
    if (state_r == S_HASH1 && step_r != 3'd0) begin
      h1_r[2'(step_r - 3'd1)] <= perm_rdata;
    end
    if (state_r == S_CELL) begin
      case (step_r)
        3'd1: grad_q_r <= grad_rom[AW'(perm_rdata)];
        3'd2: begin
          dx_r <= dx_c;
          dy_r <= dy_c;
        end
        3'd3: begin
          ax_r   <= abx[15:0];
          ay_r   <= aby[15:0];
          a2x_r  <= sqx[31:16];
          a2y_r  <= sqy[31:16];
          farx_r <= (abx[D_W-1:16] != '0);
          fary_r <= (aby[D_W-1:16] != '0);
          pgx_r  <= $signed(grad_q_r[2*GRAD_W-1:GRAD_W]) * dx_r;
          pgy_r  <= $signed(grad_q_r[GRAD_W-1:0]) * dy_r;
        end
        3'd4: begin
          ffx_r <= farx_r ? '0 : 17'(65536) - px[32:16];
          ffy_r <= fary_r ? '0 : 17'(65536) - py[32:16];
          dot_r <= 36'(pgx_r) + 36'(pgy_r);
        end
        3'd5: w_r <= wp[32:16];
        3'd6: term_r <= $signed({1'b0, w_r}) * dot_r;
        3'd7: sum_r <= sum_r + SUM_W'(term_r);
        default: ;
      endcase
    end
    if (out_load) begin
      out_data.noise_value <= (mode_r == ACT_EVAL) ? noise_c : '0;
      out_data.is_noise    <= mode_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid || !out_stall)) |=> (out_valid && state_r == S_IDLE))
    else $error("finished item did not reach the output register");

  a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.is_noise) |-> (out_data.noise_value == '0))
    else $error("load acknowledgement carries a nonzero noise value");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_HASH1 || state_r == S_DONE))
    else $error("accepted beat did not start work");

  a_cell_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CELL) |-> (ci_r != 2'd3 && cj_r != 2'd3))
    else $error("lattice cell counter out of range");
`endif

endmodule

// ===== rtl/gn2d_ram.sv =====
// Generic single-port RAM with a registered read port.
// No dependencies.
module gn2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== tb/tb_gradient_noise_2d.sv =====
// Self-checking testbench for gradient_noise_2d: random and directed load/evaluate beats.
// Depends on gn2d_pkg and the RTL top level; the predictor lives in a scoreboard class.
`timescale 1ns / 1ps

module tb_gradient_noise_2d;
  import gn2d_pkg::*;

  // Mirror of the block's table state plus the store of expected results.
  class noise_scoreboard;
    bit [7:0]        perm_q[256];
    bit [11:0]       jit_x_q[256];
    bit [11:0]       jit_y_q[256];
    longint          cos_q[256];
    longint          sin_q[256];
    gn2d_out_t       pending_q[$];
    int              mismatches;

    function new();
      for (int k = 0; k < 256; k++) begin
        cos_q[k] = phase_sine((k * 256 + 16384) & 16'hFFFF);
        sin_q[k] = phase_sine((k * 256) & 16'hFFFF);
      end
    endfunction

    // Polynomial quarter-turn sine, Q14 in and Q1.14 out.
    function longint poly_sine(longint z);
      longint z2;
      longint t;
      longint u;
      z2 = (z * z) >>> 14;
      t = 10512 - ((z2 * 1160) >>> 14);
      u = 25736 - ((z2 * t) >>> 14);
      return (z * u) >>> 14;
    endfunction

    function longint phase_sine(int ph);
      int     quad;
      longint m;
      quad = (ph >> 14) & 3;
      m = quad[0] ? poly_sine(16384 - (ph & 16383)) : poly_sine(ph & 16383);
      return quad[1] ? -m : m;
    endfunction

    // Smooth falloff 1 - (3 - 2|t|) t^2 in Q16, zero at a distance of one cell or more.
    function longint falloff_q16(longint t);
      longint a;
      longint a2;
      a = (t < 0) ? -t : t;
      if (a >= 65536) return 0;
      a2 = (a * a) >>> 16;
      return 65536 - (((196608 - 2 * a) * a2) >>> 16);
    endfunction

    function void note_beat(gn2d_in_t item);
      gn2d_out_t res;
      longint    fx, fy, cx, cy, dx, dy, w, dot, acc, v;
      bit [7:0]  h1, h;
      res = '0;
      if (item.action == ACT_LOAD) begin
        perm_q[item.table_index] = item.perm_value;
        jit_x_q[item.table_index] = item.jitter_x_value;
        jit_y_q[item.table_index] = item.jitter_y_value;
      end else begin
        fx = item.coord_x[15:0];
        fy = item.coord_y[15:0];
        cx = longint'(item.coord_x) >>> 16;
        cy = longint'(item.coord_y) >>> 16;
        acc = 0;
        for (int j = -1; j <= 1; j++) begin
          for (int i = -1; i <= 1; i++) begin
            h1 = perm_q[8'(cx + i)];
            h = perm_q[8'(h1 + cy + j)];
            dx = fx - i * 65536 - longint'(jit_x_q[h]) * 16;
            dy = fy - j * 65536 - longint'(jit_y_q[h]) * 16;
            w = (falloff_q16(dx) * falloff_q16(dy)) >>> 16;
            dot = cos_q[h] * dx + sin_q[h] * dy;
            acc += w * dot;
          end
        end
        // Round Q46 to Q12 toward nearest, ties up, then clamp to 16 bits.
        v = (acc + (longint'(1) << 33)) >>> 34;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        res.noise_value = 16'(v);
        res.is_noise = 1'b1;
      end
      pending_q.push_back(res);
    endfunction

    function void check_result(gn2d_out_t got);
      gn2d_out_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      want = pending_q.pop_front();
      if (got.noise_value !== want.noise_value || got.is_noise !== want.is_noise) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: noise %0d/%0d (exp/got), is_noise %0b/%0b",
                   want.noise_value, got.noise_value, want.is_noise, got.is_noise);
      end
    endfunction
  endclass

  localparam int DRAIN_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int IN_BITS = $bits(gn2d_in_t);

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  gn2d_in_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  gn2d_out_t out_data;

  noise_scoreboard sb = new();
  longint    cycles = 0;
  int        stall_left = 0;
  bit        stall_burst_free;  // When set, the receiver never stalls.
  bit        send_burst_free;   // When set, the sender never idles.

  gradient_noise_2d u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_gradient_noise_2d failed");
      $finish;
    end
  end

  // Result side: check every accepted beat, then draw a stall for the next one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
        stall_left = stall_burst_free ? 0 : $urandom_range(0, 19);
        out_stall <= (stall_left != 0);
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= (stall_left != 0);
      end
    end
  end

  // Present one beat after an idle gap and hold it until accepted. Valid is
  // lowered only when there really is a gap, so back-to-back beats keep it high.
  task automatic send_beat(gn2d_in_t item);
    int gap;
    gap = send_burst_free ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    sb.note_beat(item);
  endtask

  function automatic gn2d_in_t load_beat(int idx, int pv, int jx, int jy);
    gn2d_in_t b;
    b = IN_BITS'({$urandom, $urandom, $urandom, $urandom});
    b.action = ACT_LOAD;
    b.table_index = 8'(idx);
    b.perm_value = 8'(pv);
    b.jitter_x_value = 12'(jx);
    b.jitter_y_value = 12'(jy);
    return b;
  endfunction

  function automatic gn2d_in_t eval_beat(int x, int y);
    gn2d_in_t b;
    b = IN_BITS'({$urandom, $urandom, $urandom, $urandom});
    b.action = ACT_EVAL;
    b.coord_x = x;
    b.coord_y = y;
    return b;
  endfunction

  // Hold off new beats until every expected result is back, then let the
  // block settle before going on.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      2: return ($urandom_range(0, 300) << 16) | $urandom_range(0, 1);
      default: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
    endcase
  endfunction

  initial begin
    stall_burst_free = 1'b0;
    send_burst_free = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every table entry first so no evaluate ever reads an unwritten one.
    // The ends of each field's range sit at the first and last entries.
    send_beat(load_beat(0, 0, 0, 0));
    for (int k = 1; k < 255; k++)
      send_beat(load_beat(k, $urandom_range(0, 255), $urandom_range(0, 4095),
                          $urandom_range(0, 4095)));
    send_beat(load_beat(255, 255, 4095, 4095));
    wait_for_drain();

    // Directed points: origin, coordinate extremes, integer lattice points,
    // fraction extremes, the lattice wrap at the table period and one mid-run load.
    send_beat(eval_beat(0, 0));
    send_beat(eval_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_beat(eval_beat(32'h8000_0000, 32'h8000_0000));
    send_beat(eval_beat(32'h7FFF_FFFF, 32'h8000_0000));
    send_beat(eval_beat(32'hFFFF_FFFF, 32'h0000_FFFF));
    send_beat(eval_beat(32'h0001_0000, 32'hFFFF_0000));
    send_beat(eval_beat(32'h0000_8000, 32'h0000_8000));
    send_beat(eval_beat(32'h00FF_C000, 32'h0100_4000));
    send_beat(eval_beat(32'h0100_4000, 32'h00FF_C000));
    send_beat(eval_beat(32'h0300_8000, 32'h0000_8000));
    send_beat(eval_beat(32'hFF00_8000, 32'h5555_AAAA));
    send_beat(eval_beat(32'hAAAA_5555, 32'h0000_0001));
    send_beat(load_beat(300, 7, 4095, 0));
    send_beat(eval_beat(32'h0000_0001, 32'hFFFF_FFFF));
    wait_for_drain();

    // Random mix, mostly evaluates, with bursts free of idling on either side.
    for (int n = 0; n < 430; n++) begin
      if (n % 50 == 0) begin
        send_burst_free = ($urandom_range(0, 3) == 0);
        stall_burst_free = ($urandom_range(0, 3) == 0);
      end
      if (n == 215) wait_for_drain();
      if ($urandom_range(0, 3) == 0)
        send_beat(load_beat($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 4095), $urandom_range(0, 4095)));
      else
        send_beat(eval_beat(rand_coord(), rand_coord()));
    end
    in_valid <= 1'b0;
    stall_burst_free = 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("tb_gradient_noise_2d passed");
    end else begin
      $display("tb_gradient_noise_2d failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gn2d_pkg.sv
rtl/gn2d_ram.sv
rtl/gradient_noise_2d.sv
tb/tb_gradient_noise_2d.sv
